/* rtl/stq_pkg.sv */
// shared types, sizes and codes of the strict priority task queues
package stq_pkg;

    // queue geometry
    localparam int NUM_LEVELS  = 4;
    localparam int LEVEL_DEPTH = 16;
    localparam int STORE_DEPTH = NUM_LEVELS * LEVEL_DEPTH;

    // derived widths
    localparam int LVL_W  = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int PTR_W  = $clog2(LEVEL_DEPTH);
    localparam int OCC_W  = $clog2(LEVEL_DEPTH + 1);
    localparam int ADDR_W = $clog2(STORE_DEPTH);

    // field widths
    localparam int OP_W     = 2;
    localparam int HANDLE_W = 32;
    localparam int PRIO_W   = 4;
    localparam int DPRIO_W  = 2;
    localparam int TOTAL_W  = 7;
    localparam int ENTRY_W  = HANDLE_W + 1;

    // reset value of the default level register
    localparam logic [DPRIO_W-1:0] DEFAULT_PRIO_RESET = DPRIO_W'(3);

    // operation codes, any other code is handled as a pop
    localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
    localparam logic [OP_W-1:0] OP_POP   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    typedef enum logic [2:0] {
        STAT_PUSHED  = 3'd0,
        STAT_POPPED  = 3'd1,
        STAT_EMPTY   = 3'd2,
        STAT_FULL    = 3'd3,
        STAT_BADLVL  = 3'd4,
        STAT_CLEARED = 3'd5
    } status_t;

    // outcome of one request as decided by the pointer file
    typedef struct packed {
        logic                 is_pop;
        logic                 ram_we;
        logic                 ram_re;
        logic [ADDR_W-1:0]    ram_addr;
        status_t              status;
        logic [TOTAL_W-1:0]   total;
    } decision_t;

endpackage

/* rtl/strict_priority_task_queues.sv */
// top level of the strict priority task queues
//
// Holds one FIFO of task handles per priority level, level 0 served first.
// Input channel s_*: a request (push, pop or clear) moves on a transfer with
// s_valid and s_ready high. Output channel m_*: one result per request,
// carrying status, dequeued handle and the total task count after the step.
// Push, clear and rejected pushes give their result in the cycle after the
// input transfer; a pop gives it later, since the entry is first read into the
// registered read data of the single port entry ram and then into the result
// register. Throughput: one push or clear per cycle when the receiver keeps
// m_ready high; a pop holds off the next request until its result is
// registered. The entry ram port and the single result register set these limits.
// The receiver may stall: the result waits in its register and s_ready stays
// low until it is taken.
// cfg_we writes the default level (used for pushes without a task) at once;
// write it only while no request is in flight.
// Reset (aresetn low, synchronous) empties every level, zeroes the count and
// sets the default level to 3; the entry ram is not cleared.
module strict_priority_task_queues (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [stq_pkg::DPRIO_W-1:0]   cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [stq_pkg::OP_W-1:0]      s_op,
    input  logic [stq_pkg::HANDLE_W-1:0]  s_task_handle,
    input  logic                          s_task_present,
    input  logic [stq_pkg::PRIO_W-1:0]    s_priority_req,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [2:0]                    m_status,
    output logic [stq_pkg::HANDLE_W-1:0]  m_out_handle,
    output logic                          m_out_present,
    output logic [stq_pkg::TOTAL_W-1:0]   m_total_count
);

    typedef enum logic {
        S_IDLE,
        S_POP_WAIT
    } state_t;

    state_t                         state_reg;
    logic                           m_valid_reg;
    stq_pkg::status_t               status_reg;
    logic [stq_pkg::HANDLE_W-1:0]   handle_reg;
    logic                           present_reg;
    logic [stq_pkg::TOTAL_W-1:0]    total_reg;
    logic [stq_pkg::DPRIO_W-1:0]    dprio_reg;

    logic                           s_fire;
    stq_pkg::decision_t             dec;
    logic [stq_pkg::ENTRY_W-1:0]    ram_wdata;
    logic [stq_pkg::ENTRY_W-1:0]    ram_rdata;

    // accept only in the idle state, with the result register free or being emptied
    assign s_ready = (state_reg == S_IDLE) && (!m_valid_reg || m_ready);
    assign s_fire  = s_valid && s_ready;

    // default level register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dprio_reg <= stq_pkg::DEFAULT_PRIO_RESET;
        end else if (cfg_we) begin
            dprio_reg <= cfg_wdata;
        end
    end

    // per level pointers and request decision
    stq_ptrs u_ptrs (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd_fire         (s_fire),
        .op               (s_op),
        .task_present     (s_task_present),
        .priority_req     (s_priority_req),
        .default_priority (dprio_reg),
        .dec              (dec)
    );

    // null tasks are stored as all zero
    assign ram_wdata = s_task_present ? {1'b1, s_task_handle} : '0;

    stq_ram #(
        .DATA_W (stq_pkg::ENTRY_W),
        .DEPTH  (stq_pkg::STORE_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (dec.ram_we),
        .re    (dec.ram_re),
        .addr  (dec.ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // sequencer and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (s_fire) begin
                        status_reg  <= dec.status;
                        total_reg   <= dec.total;
                        handle_reg  <= '0;
                        present_reg <= 1'b0;
                        if (dec.is_pop) begin
                            state_reg   <= S_POP_WAIT;
                            m_valid_reg <= 1'b0;
                        end else begin
                            m_valid_reg <= 1'b1;
                        end
                    end else if (m_ready) begin
                        m_valid_reg <= 1'b0;
                    end
                end
                S_POP_WAIT: begin
                    if (status_reg == stq_pkg::STAT_POPPED) begin
                        handle_reg  <= ram_rdata[stq_pkg::HANDLE_W-1:0];
                        present_reg <= ram_rdata[stq_pkg::HANDLE_W];
                    end
                    m_valid_reg <= 1'b1;
                    state_reg   <= S_IDLE;
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = status_reg;
    assign m_out_handle  = handle_reg;
    assign m_out_present = present_reg;
    assign m_total_count = total_reg;

endmodule

/* rtl/stq_ram.sv */
// generic single port synchronous ram with registered read data
module stq_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [DATA_W-1:0]        wdata,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/stq_ptrs.sv */
// head, tail and occupancy bookkeeping per level plus the request decision
module stq_ptrs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cmd_fire,
    input  logic [stq_pkg::OP_W-1:0]            op,
    input  logic                                task_present,
    input  logic [stq_pkg::PRIO_W-1:0]          priority_req,
    input  logic [stq_pkg::DPRIO_W-1:0]         default_priority,
    output stq_pkg::decision_t                  dec
);

    logic [stq_pkg::PTR_W-1:0]   head_reg [stq_pkg::NUM_LEVELS];
    logic [stq_pkg::PTR_W-1:0]   head_next [stq_pkg::NUM_LEVELS];
    logic [stq_pkg::PTR_W-1:0]   tail_reg [stq_pkg::NUM_LEVELS];
    logic [stq_pkg::PTR_W-1:0]   tail_next [stq_pkg::NUM_LEVELS];
    logic [stq_pkg::OCC_W-1:0]   occ_reg [stq_pkg::NUM_LEVELS];
    logic [stq_pkg::OCC_W-1:0]   occ_next [stq_pkg::NUM_LEVELS];
    logic [stq_pkg::TOTAL_W-1:0] total_reg;
    logic [stq_pkg::TOTAL_W-1:0] total_next;

    logic [stq_pkg::PRIO_W-1:0]  req_lvl;
    logic [stq_pkg::LVL_W-1:0]   push_lvl;
    logic                        bad_lvl;
    logic                        lvl_full;
    logic                        found;
    logic [stq_pkg::LVL_W-1:0]   pop_lvl;
    logic                        is_pop;
    logic [stq_pkg::PTR_W-1:0]   tail_ptr;
    logic [stq_pkg::PTR_W-1:0]   head_ptr;

    // wrap a pointer at the level depth
    function automatic logic [stq_pkg::PTR_W-1:0] advance(
        input logic [stq_pkg::PTR_W-1:0] p
    );
        if (p == stq_pkg::PTR_W'(stq_pkg::LEVEL_DEPTH - 1)) begin
            return '0;
        end
        return p + stq_pkg::PTR_W'(1);
    endfunction

    // push level and its checks
    always_comb begin
        req_lvl  = task_present ? priority_req
                                : stq_pkg::PRIO_W'(default_priority);
        push_lvl = req_lvl[stq_pkg::LVL_W-1:0];
        bad_lvl  = int'(req_lvl) >= stq_pkg::NUM_LEVELS;
        lvl_full = occ_reg[push_lvl] == stq_pkg::OCC_W'(stq_pkg::LEVEL_DEPTH);
        tail_ptr = tail_reg[push_lvl];
    end

    // lowest numbered level that holds an entry
    always_comb begin
        found   = 1'b0;
        pop_lvl = '0;
        for (int i = stq_pkg::NUM_LEVELS - 1; i >= 0; i--) begin
            if (occ_reg[i] != '0) begin
                found   = 1'b1;
                pop_lvl = stq_pkg::LVL_W'(i);
            end
        end
        head_ptr = head_reg[pop_lvl];
    end

    // decision and next state
    always_comb begin
        is_pop     = (op != stq_pkg::OP_PUSH) && (op != stq_pkg::OP_CLEAR);
        head_next  = head_reg;
        tail_next  = tail_reg;
        occ_next   = occ_reg;
        total_next = total_reg;
        dec        = '0;
        dec.is_pop = is_pop;
        dec.status = stq_pkg::STAT_EMPTY;
        priority if (op == stq_pkg::OP_PUSH) begin
            priority if (bad_lvl) begin
                dec.status = stq_pkg::STAT_BADLVL;
            end else if (lvl_full) begin
                dec.status = stq_pkg::STAT_FULL;
            end else begin
                dec.status   = stq_pkg::STAT_PUSHED;
                dec.ram_we   = 1'b1;
                dec.ram_addr = stq_pkg::ADDR_W'(int'(push_lvl) * stq_pkg::LEVEL_DEPTH
                                                + int'(tail_ptr));
                tail_next[push_lvl] = advance(tail_ptr);
                occ_next[push_lvl]  = occ_reg[push_lvl] + stq_pkg::OCC_W'(1);
                total_next          = total_reg + stq_pkg::TOTAL_W'(1);
            end
        end else if (op == stq_pkg::OP_CLEAR) begin
            dec.status = stq_pkg::STAT_CLEARED;
            for (int i = 0; i < stq_pkg::NUM_LEVELS; i++) begin
                head_next[i] = '0;
                tail_next[i] = '0;
                occ_next[i]  = '0;
            end
            total_next = '0;
        end else if (found) begin
            dec.status   = stq_pkg::STAT_POPPED;
            dec.ram_re   = 1'b1;
            dec.ram_addr = stq_pkg::ADDR_W'(int'(pop_lvl) * stq_pkg::LEVEL_DEPTH
                                            + int'(head_ptr));
            head_next[pop_lvl] = advance(head_ptr);
            occ_next[pop_lvl]  = occ_reg[pop_lvl] - stq_pkg::OCC_W'(1);
            if (total_reg != '0) begin
                total_next = total_reg - stq_pkg::TOTAL_W'(1);
            end
        end else begin
            // pop with every level empty
            dec.status = stq_pkg::STAT_EMPTY;
        end
        dec.total = total_next;
        if (!cmd_fire) begin
            dec.ram_we = 1'b0;
            dec.ram_re = 1'b0;
        end
    end

    // pointer and count registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < stq_pkg::NUM_LEVELS; i++) begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                occ_reg[i]  <= '0;
            end
            total_reg <= '0;
        end else if (cmd_fire) begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            occ_reg   <= occ_next;
            total_reg <= total_next;
        end
    end

endmodule

/* rtl/stq_checker.sv */
// port level checks of the strict priority task queues and their binding
module stq_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic [stq_pkg::OP_W-1:0]      s_op,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [2:0]                    m_status,
    input logic [stq_pkg::HANDLE_W-1:0]  m_out_handle,
    input logic                          m_out_present,
    input logic [stq_pkg::TOTAL_W-1:0]   m_total_count
);

    logic in_pop;

    assign in_pop = s_valid && s_ready && (s_op != stq_pkg::OP_PUSH)
                    && (s_op != stq_pkg::OP_CLEAR);

    // a stalled result blocks new requests
    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("request taken while result stalled");

    // push and clear results show up in the cycle after the transfer
    a_push_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_op == stq_pkg::OP_PUSH || s_op == stq_pkg::OP_CLEAR)
        |=> m_valid)
        else $error("push or clear result missing");

    // a pop holds off the next request while its entry is read, then answers
    a_pop_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        in_pop |=> !s_ready ##1 m_valid)
        else $error("pop sequencing broken");

    // only a successful pop returns a handle
    a_handle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != stq_pkg::STAT_POPPED) |->
        (m_out_handle == '0) && !m_out_present)
        else $error("handle on a result that is not a pop");

    // count never exceeds the total capacity and the status stays in range
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (int'(m_total_count) <= stq_pkg::STORE_DEPTH)
                    && (int'(m_status) <= int'(stq_pkg::STAT_CLEARED)))
        else $error("count or status out of range");

endmodule

bind strict_priority_task_queues stq_checker u_stq_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_op          (s_op),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_status      (m_status),
    .m_out_handle  (m_out_handle),
    .m_out_present (m_out_present),
    .m_total_count (m_total_count)
);

/* tb/tb_top.sv */
// testbench for the strict priority task queues: mirrored queue model with directed and random traffic
`timescale 1ns / 1ps

// one expected outcome of a request
typedef struct {
    stq_pkg::status_t             status;
    logic [stq_pkg::HANDLE_W-1:0] handle;
    logic                         present;
    logic [stq_pkg::TOTAL_W-1:0]  total;
} queue_outcome_t;

// mirror of the level fifos plus the outcomes still owed by the block
class priority_queue_mirror;
    logic [stq_pkg::ENTRY_W-1:0] slots [stq_pkg::STORE_DEPTH];
    int unsigned                 head [stq_pkg::NUM_LEVELS];
    int unsigned                 tail [stq_pkg::NUM_LEVELS];
    int unsigned                 occ [stq_pkg::NUM_LEVELS];
    int unsigned                 held;
    logic [stq_pkg::DPRIO_W-1:0] default_level;
    queue_outcome_t              owed [$];
    int                          errors;
    int                          results_seen;

    function new();
        empty_levels();
        default_level = stq_pkg::DEFAULT_PRIO_RESET;
        errors = 0;
        results_seen = 0;
    endfunction

    function void empty_levels();
        for (int i = 0; i < stq_pkg::NUM_LEVELS; i++) begin
            head[i] = 0;
            tail[i] = 0;
            occ[i] = 0;
        end
        held = 0;
    endfunction

    function int pending();
        return owed.size();
    endfunction

    // apply one accepted request and queue the outcome it must produce
    function void log_request(logic [stq_pkg::OP_W-1:0] op,
                              logic [stq_pkg::HANDLE_W-1:0] handle,
                              logic present, logic [stq_pkg::PRIO_W-1:0] prio);
        queue_outcome_t o;
        int unsigned    lvl;
        int unsigned    at;
        bit             found;
        o.status = stq_pkg::STAT_EMPTY;
        o.handle = '0;
        o.present = 1'b0;
        found = 1'b0;
        case (op)
            stq_pkg::OP_PUSH: begin
                lvl = present ? int'(prio) : int'(default_level);
                if (lvl >= stq_pkg::NUM_LEVELS) begin
                    o.status = stq_pkg::STAT_BADLVL;
                end else if (occ[lvl] >= stq_pkg::LEVEL_DEPTH) begin
                    o.status = stq_pkg::STAT_FULL;
                end else begin
                    at = lvl * stq_pkg::LEVEL_DEPTH + tail[lvl];
                    // a null task is stored as an all-zero entry
                    slots[at] = present ? {1'b1, handle} : '0;
                    tail[lvl] = (tail[lvl] + 1) % stq_pkg::LEVEL_DEPTH;
                    occ[lvl]++;
                    held++;
                    o.status = stq_pkg::STAT_PUSHED;
                end
            end
            stq_pkg::OP_CLEAR: begin
                empty_levels();
                o.status = stq_pkg::STAT_CLEARED;
            end
            default: begin
                // pop, the undefined code included: lowest non-empty level wins
                for (int i = 0; i < stq_pkg::NUM_LEVELS; i++) begin
                    if (!found && occ[i] != 0) begin
                        at = i * stq_pkg::LEVEL_DEPTH + head[i];
                        o.handle = slots[at][stq_pkg::HANDLE_W-1:0];
                        o.present = slots[at][stq_pkg::HANDLE_W];
                        head[i] = (head[i] + 1) % stq_pkg::LEVEL_DEPTH;
                        occ[i]--;
                        if (held != 0)
                            held--;
                        o.status = stq_pkg::STAT_POPPED;
                        found = 1'b1;
                    end
                end
            end
        endcase
        o.total = held[stq_pkg::TOTAL_W-1:0];
        owed.insert(owed.size(), o);
    endfunction

    task report_mismatch(string msg);
        $display("mismatch at result %0d: %s", results_seen, msg);
        errors++;
    endtask

    // compare one result transfer with the oldest owed outcome
    task check_outcome(logic [2:0] status, logic [stq_pkg::HANDLE_W-1:0] handle,
                       logic present, logic [stq_pkg::TOTAL_W-1:0] total);
        queue_outcome_t o;
        results_seen++;
        if (owed.size() == 0) begin
            report_mismatch("result transfer with nothing outstanding");
        end else begin
            o = owed[0];
            owed.delete(0);
            if (status !== o.status)
                report_mismatch($sformatf("status %0d, want %0d", status, o.status));
            if (handle !== o.handle)
                report_mismatch($sformatf("handle %h, want %h", handle, o.handle));
            if (present !== o.present)
                report_mismatch($sformatf("present %b, want %b", present, o.present));
            if (total !== o.total)
                report_mismatch($sformatf("total %0d, want %0d", total, o.total));
        end
    endtask
endclass

module tb_top;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 475;
    // undefined op code, decoded by the block as a pop
    localparam logic [stq_pkg::OP_W-1:0] OP_UNDEF = 2'd3;

    logic                         aclk = 1'b0;
    logic                         aresetn;
    logic                         cfg_we;
    logic [stq_pkg::DPRIO_W-1:0]  cfg_wdata;
    logic                         s_valid;
    logic                         s_ready;
    logic [stq_pkg::OP_W-1:0]     s_op;
    logic [stq_pkg::HANDLE_W-1:0] s_task_handle;
    logic                         s_task_present;
    logic [stq_pkg::PRIO_W-1:0]   s_priority_req;
    logic                         m_valid;
    logic                         m_ready = 1'b0;
    logic [2:0]                   m_status;
    logic [stq_pkg::HANDLE_W-1:0] m_out_handle;
    logic                         m_out_present;
    logic [stq_pkg::TOTAL_W-1:0]  m_total_count;

    int unsigned src_idle_pct = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned cycle_count = 0;

    priority_queue_mirror mirror = new();

    strict_priority_task_queues dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_task_handle  (s_task_handle),
        .s_task_present (s_task_present),
        .s_priority_req (s_priority_req),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_out_handle   (m_out_handle),
        .m_out_present  (m_out_present),
        .m_total_count  (m_total_count)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // receiver back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // watch both channels for transfers
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                mirror.log_request(s_op, s_task_handle, s_task_present, s_priority_req);
            if (m_valid && m_ready)
                mirror.check_outcome(m_status, m_out_handle, m_out_present, m_total_count);
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("strict_priority_task_queues test failed");
            $finish;
        end
    end

    // present one request and hold it until the transfer
    task automatic send_request(input logic [stq_pkg::OP_W-1:0] op,
                                input logic [stq_pkg::HANDLE_W-1:0] handle,
                                input logic present,
                                input logic [stq_pkg::PRIO_W-1:0] prio);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_op <= op;
        s_task_handle <= handle;
        s_task_present <= present;
        s_priority_req <= prio;
        do
            @(posedge aclk);
        while (!s_ready);
    endtask

    // stop sending and let every owed result come back
    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (mirror.pending() != 0)
            @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_default_level(input logic [stq_pkg::DPRIO_W-1:0] lvl);
        cfg_wdata <= lvl;
        cfg_we <= 1'b1;
        @(posedge aclk);
        cfg_we <= 1'b0;
        mirror.default_level = lvl;
    endtask

    // one push with random content, mostly to valid levels
    task automatic send_random_push(input int lvl);
        logic pres;
        logic [stq_pkg::PRIO_W-1:0] prio;
        pres = ($urandom_range(7) != 0);
        if (lvl >= 0)
            prio = stq_pkg::PRIO_W'(lvl);
        else if ($urandom_range(9) == 0)
            prio = stq_pkg::PRIO_W'($urandom);
        else
            prio = stq_pkg::PRIO_W'($urandom_range(stq_pkg::NUM_LEVELS - 1));
        if (!pres)
            prio = stq_pkg::PRIO_W'($urandom);
        send_request(stq_pkg::OP_PUSH, $urandom, pres, prio);
    endtask

    // random traffic built from fill bursts, pop bursts, mixed runs, fill-all runs, clears and drains
    task automatic run_random(input int n_items);
        int sent;
        int kind;
        int n;
        int lvl;
        int pick;
        sent = 0;
        while (sent < n_items) begin
            kind = $urandom_range(99);
            if (kind < 28) begin
                // fill burst on one level, often running into full
                lvl = $urandom_range(stq_pkg::NUM_LEVELS - 1);
                n = $urandom_range(4, 20);
                for (int k = 0; k < n; k++)
                    send_random_push(lvl);
                sent += n;
            end else if (kind < 52) begin
                n = $urandom_range(4, 20);
                for (int k = 0; k < n; k++)
                    send_request(($urandom_range(9) == 0) ? OP_UNDEF : stq_pkg::OP_POP,
                                 $urandom, 1'($urandom), stq_pkg::PRIO_W'($urandom));
                sent += n;
            end else if (kind < 88) begin
                n = $urandom_range(5, 30);
                for (int k = 0; k < n; k++) begin
                    pick = $urandom_range(99);
                    if (pick < 45)
                        send_random_push(-1);
                    else if (pick < 85)
                        send_request(stq_pkg::OP_POP, $urandom, 1'($urandom),
                                     stq_pkg::PRIO_W'($urandom));
                    else if (pick < 92)
                        send_request(OP_UNDEF, $urandom, 1'($urandom),
                                     stq_pkg::PRIO_W'($urandom));
                    else if (pick < 95)
                        send_request(stq_pkg::OP_CLEAR, $urandom, 1'($urandom),
                                     stq_pkg::PRIO_W'($urandom));
                    else
                        send_request(stq_pkg::OP_PUSH, $urandom, 1'b1,
                                     stq_pkg::PRIO_W'($urandom_range(stq_pkg::NUM_LEVELS,
                                                                     15)));
                end
                sent += n;
            end else if (kind < 94) begin
                // every level to full and one over, total reaches its top
                for (int l = 0; l < stq_pkg::NUM_LEVELS; l++)
                    for (int k = 0; k <= stq_pkg::LEVEL_DEPTH; k++)
                        send_request(stq_pkg::OP_PUSH, $urandom, 1'b1,
                                     stq_pkg::PRIO_W'(l));
                sent += stq_pkg::NUM_LEVELS * (stq_pkg::LEVEL_DEPTH + 1);
            end else if (kind < 97) begin
                send_request(stq_pkg::OP_CLEAR, $urandom, 1'($urandom),
                             stq_pkg::PRIO_W'($urandom));
                sent++;
            end else begin
                wait_for_results();
            end
        end
    endtask

    initial begin
        logic [stq_pkg::DPRIO_W-1:0] phase_level [4];
        int unsigned                 phase_idle [4];
        int unsigned                 phase_stall [4];
        phase_level = '{2'd0, 2'd2, 2'd1, 2'd3};
        phase_idle = '{0, 55, 0, 17};
        phase_stall = '{0, 0, 55, 17};
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_op = stq_pkg::OP_POP;
        s_task_handle = '0;
        s_task_present = 1'b0;
        s_priority_req = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty pops, extremes, null task, bad levels, ordering, clear
        send_request(stq_pkg::OP_POP, 32'hFFFF_FFFF, 1'b1, 4'hF);
        send_request(OP_UNDEF, '0, 1'b0, '0);
        send_request(stq_pkg::OP_PUSH, 32'hFFFF_FFFF, 1'b1, 4'd0);
        send_request(stq_pkg::OP_PUSH, 32'h0000_0000, 1'b1, 4'd3);
        send_request(stq_pkg::OP_PUSH, 32'hA5A5_A5A5, 1'b0, 4'hF);
        send_request(stq_pkg::OP_PUSH, 32'h1111_1111, 1'b1, 4'd4);
        send_request(stq_pkg::OP_PUSH, 32'h2222_2222, 1'b1, 4'hF);
        send_request(stq_pkg::OP_PUSH, 32'h1234_5678, 1'b1, 4'd2);
        send_request(stq_pkg::OP_PUSH, 32'h8000_0001, 1'b1, 4'd1);
        send_request(stq_pkg::OP_PUSH, 32'h0000_0002, 1'b1, 4'd0);
        send_request(stq_pkg::OP_POP, '0, 1'b0, '0);
        send_request(stq_pkg::OP_POP, '0, 1'b0, '0);
        send_request(OP_UNDEF, '0, 1'b0, '0);
        send_request(stq_pkg::OP_POP, '0, 1'b0, '0);
        send_request(stq_pkg::OP_POP, '0, 1'b0, '0);
        send_request(stq_pkg::OP_POP, '0, 1'b0, '0);
        send_request(stq_pkg::OP_POP, '0, 1'b0, '0);
        send_request(stq_pkg::OP_PUSH, 32'h5A5A_5A5A, 1'b1, 4'd1);
        send_request(stq_pkg::OP_PUSH, 32'h0F0F_0F0F, 1'b0, 4'd0);
        send_request(stq_pkg::OP_CLEAR, 32'hFFFF_FFFF, 1'b1, 4'hF);
        send_request(stq_pkg::OP_POP, '0, 1'b0, '0);
        send_request(stq_pkg::OP_CLEAR, '0, 1'b0, '0);
        wait_for_results();

        // random phases, each under its own default level and idling mix
        for (int ph = 0; ph < 4; ph++) begin
            src_idle_pct = phase_idle[ph];
            sink_stall_pct = phase_stall[ph];
            write_default_level(phase_level[ph]);
            run_random(PHASE_ITEMS);
            wait_for_results();
        end

        if (mirror.pending() != 0)
            mirror.report_mismatch($sformatf("%0d results never arrived", mirror.pending()));
        if (mirror.errors == 0)
            $display("strict_priority_task_queues test passed");
        else
            $display("strict_priority_task_queues test failed");
        $finish;
    end
endmodule
